>>> hdl/mtem_pkg.sv
`default_nettype none

package mtem_pkg;

  // Field widths of the stream payloads
  localparam int FUNC_W      = 3;
  localparam int ID_W        = 4;
  localparam int VAL_W       = 32;
  localparam int EV_W        = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  // At most this many expiry results per tick transaction
  localparam int MAX_RES = 16;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK     = 3'd0,
    FN_START    = 3'd1,
    FN_STOP     = 3'd2,
    FN_SETP     = 3'd3,
    FN_GETP     = 3'd4,
    FN_ONESHOT  = 3'd5,
    FN_PERIODIC = 3'd6,
    FN_INVALID  = 3'd7
  } func_e;

  typedef enum logic [EV_W-1:0] {
    EV_DONE = 2'd0,
    EV_ERR  = 2'd1,
    EV_EXP  = 2'd2
  } ev_e;

  // Controller -> datapath
  typedef struct packed {
    logic accept;     // latch input transaction
    logic tick;       // advance counter, open first scan pass
    logic scan_init;  // rewind scan pointer, clear best
    logic scan_rd;    // read entry at scan pointer
    logic emit_exp;   // load expiry result, update winner
    logic cmd_exec;   // load command result, update state
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_is_tick;
    logic ptr_last;
    logic best_found;
    logic exp_last;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/mtem_ram.sv
`default_nettype none

module mtem_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/mtem_ctrl.sv
`default_nettype none

module mtem_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire mtem_pkg::dp_stat_t    stat_i,
  output mtem_pkg::ctrl_cmd_t        cmd_o
);

  import mtem_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TICK   = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_TAIL   = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_CMD_RD = 7'b0100000,
    S_CMD_EX = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = stat_i.in_is_tick ? S_TICK : S_CMD_RD;
        end
      end
      S_TICK: begin
        cmd_o.tick      = 1'b1;
        cmd_o.scan_init = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.ptr_last) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!stat_i.best_found) begin
          state_d = S_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.emit_exp = 1'b1;
          if (stat_i.exp_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end
        end
      end
      S_CMD_RD: begin
        state_d = S_CMD_EX;
      end
      S_CMD_EX: begin
        if (stat_i.out_free) begin
          cmd_o.cmd_exec = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/mtem_dp.sv
`default_nettype none

module mtem_dp #(
  parameter int TIMERS    = 16,
  parameter int TICK_BITS = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire mtem_pkg::ctrl_cmd_t                   cmd_i,
  output mtem_pkg::dp_stat_t                         stat_o,
  input  wire logic [mtem_pkg::FUNC_W-1:0]           in_user_i,
  input  wire logic [mtem_pkg::IN_TDATA_W-1:0]       in_data_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic      [mtem_pkg::EV_W-1:0]             out_user_o,
  output logic      [mtem_pkg::OUT_TDATA_W-1:0]      out_data_o,
  output logic                                       out_last_o
);

  import mtem_pkg::*;

  localparam int AW    = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int SLOTS = 1 << AW;
  localparam int CTW   = $clog2(TIMERS + 1);
  localparam int NW    = $clog2(MAX_RES + 1);
  localparam int CMPW  = ((CTW > NW) ? CTW : NW) + 1;
  localparam int IXW   = ((ID_W > AW) ? ID_W : AW) + 1;
  localparam logic [TICK_BITS-1:0] HALF = {1'b0, {(TICK_BITS-1){1'b1}}};

  // latched command
  func_e             func_q;
  logic [ID_W-1:0]   idx_q;
  logic [VAL_W-1:0]  pv_q;

  // timer state
  logic [TICK_BITS-1:0] now_q;
  logic [SLOTS-1:0]     active_q, rep_q, dl_vld_q, pr_vld_q, cand_q;

  // scan pipeline
  logic [AW-1:0]        ptr_q, rd_idx_q;
  logic                 rd_ok_q, dl_vrd_q, pr_vrd_q, first_q;
  logic                 best_found_q;
  logic [AW-1:0]        best_idx_q;
  logic [TICK_BITS-1:0] best_age_q, best_dl_q, best_pr_q;
  logic [CTW-1:0]       total_q;
  logic [NW-1:0]        n_q;

  // output register
  logic              out_valid_q, out_last_q;
  ev_e               out_ev_q;
  logic [ID_W-1:0]   out_id_q;
  logic [VAL_W-1:0]  out_val_q;

  // RAM ports
  logic [AW-1:0]        raddr, dl_waddr;
  logic                 dl_we, pr_we;
  logic [TICK_BITS-1:0] dl_ram_q, pr_ram_q, dl_wdata;

  // command decode
  logic [ID_W+AW-1:0]       idx_ext;
  logic [AW-1:0]            cmd_addr;
  logic                     idx_ok;
  logic [TICK_BITS+VAL_W-1:0] pv_ext;
  logic [TICK_BITS-1:0]     pv_t;
  logic [TICK_BITS-1:0]     dl_rd, pr_rd, age;
  logic [TICK_BITS+VAL_W-1:0] pr_ext, bdl_ext;
  logic [AW+ID_W-1:0]       bi_ext;
  logic                     elig, better, rearm;
  logic [CMPW-1:0]          n_nxt, total_ext;
  ev_e                      ev_c;
  logic [VAL_W-1:0]         val_c;
  logic                     do_start, do_stop, do_setp, do_one, do_per;

  assign idx_ext  = {{AW{1'b0}}, idx_q};
  assign cmd_addr = idx_ext[AW-1:0];
  assign idx_ok   = {{(IXW-ID_W){1'b0}}, idx_q} < IXW'(TIMERS);
  assign pv_ext   = {{TICK_BITS{1'b0}}, pv_q};
  assign pv_t     = pv_ext[TICK_BITS-1:0];

  assign raddr = cmd_i.scan_rd ? ptr_q : cmd_addr;
  assign dl_rd = dl_vrd_q ? dl_ram_q : '0;
  assign pr_rd = pr_vrd_q ? pr_ram_q : '0;
  assign age   = now_q - dl_rd;

  assign elig   = first_q ? (active_q[rd_idx_q] && (age < HALF)) : cand_q[rd_idx_q];
  assign better = !best_found_q || (age > best_age_q);
  assign rearm  = rep_q[best_idx_q] && (best_pr_q < HALF);

  assign n_nxt     = CMPW'(n_q) + CMPW'(1);
  assign total_ext = CMPW'(total_q);

  assign pr_ext  = {{VAL_W{1'b0}}, pr_rd};
  assign bdl_ext = {{VAL_W{1'b0}}, best_dl_q};
  assign bi_ext  = {{ID_W{1'b0}}, best_idx_q};

  always_comb begin
    ev_c     = EV_DONE;
    val_c    = '0;
    do_start = 1'b0;
    do_stop  = 1'b0;
    do_setp  = 1'b0;
    do_one   = 1'b0;
    do_per   = 1'b0;
    if (!idx_ok || func_q == FN_INVALID) begin
      ev_c = EV_ERR;
    end else begin
      case (func_q)
        FN_START: begin
          if (pr_rd >= HALF) ev_c = EV_ERR;
          else do_start = 1'b1;
        end
        FN_STOP: begin
          if (!active_q[cmd_addr]) ev_c = EV_ERR;
          else do_stop = 1'b1;
        end
        FN_SETP:     do_setp = 1'b1;
        FN_GETP:     val_c   = pr_ext[VAL_W-1:0];
        FN_ONESHOT:  do_one  = 1'b1;
        FN_PERIODIC: do_per  = 1'b1;
        default: ;
      endcase
    end
  end

  // deadline store: written by start or by a periodic re-arm
  assign dl_we    = (cmd_i.cmd_exec && do_start) || (cmd_i.emit_exp && rearm);
  assign dl_waddr = cmd_i.emit_exp ? best_idx_q : cmd_addr;
  assign dl_wdata = now_q + (cmd_i.emit_exp ? best_pr_q : pr_rd);
  assign pr_we    = cmd_i.cmd_exec && do_setp;

  mtem_ram #(.WIDTH(TICK_BITS), .DEPTH(TIMERS)) u_dl_ram (
    .clk_i   (clk_i),
    .we_i    (dl_we),
    .waddr_i (dl_waddr),
    .wdata_i (dl_wdata),
    .raddr_i (raddr),
    .rdata_o (dl_ram_q)
  );

  mtem_ram #(.WIDTH(TICK_BITS), .DEPTH(TIMERS)) u_pr_ram (
    .clk_i   (clk_i),
    .we_i    (pr_we),
    .waddr_i (cmd_addr),
    .wdata_i (pv_t),
    .raddr_i (raddr),
    .rdata_o (pr_ram_q)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q        <= '0;
      active_q     <= '0;
      rep_q        <= '0;
      dl_vld_q     <= '0;
      pr_vld_q     <= '0;
      cand_q       <= '0;
      first_q      <= 1'b0;
      best_found_q <= 1'b0;
      rd_ok_q      <= 1'b0;
      total_q      <= '0;
      n_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      rd_ok_q <= cmd_i.scan_rd;
      if (cmd_i.tick) begin
        now_q   <= now_q + TICK_BITS'(1);
        first_q <= 1'b1;
        total_q <= '0;
        n_q     <= '0;
      end
      if (cmd_i.scan_init) begin
        best_found_q <= 1'b0;
      end
      if (rd_ok_q) begin
        if (first_q) begin
          cand_q[rd_idx_q] <= elig;
          if (elig) total_q <= total_q + CTW'(1);
        end
        if (elig && better) best_found_q <= 1'b1;
      end
      if (cmd_i.emit_exp) begin
        first_q            <= 1'b0;
        n_q                <= n_q + NW'(1);
        cand_q[best_idx_q] <= 1'b0;
        if (rearm) dl_vld_q[best_idx_q] <= 1'b1;
        else active_q[best_idx_q] <= 1'b0;
      end
      if (cmd_i.cmd_exec) begin
        if (do_start) begin
          active_q[cmd_addr] <= 1'b1;
          dl_vld_q[cmd_addr] <= 1'b1;
        end
        if (do_stop) active_q[cmd_addr] <= 1'b0;
        if (do_setp) pr_vld_q[cmd_addr] <= 1'b1;
        if (do_one)  rep_q[cmd_addr]    <= 1'b0;
        if (do_per)  rep_q[cmd_addr]    <= 1'b1;
      end
      if (cmd_i.emit_exp || cmd_i.cmd_exec) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dl_vrd_q <= dl_vld_q[raddr];
    pr_vrd_q <= pr_vld_q[raddr];
    rd_idx_q <= ptr_q;
    if (cmd_i.accept) begin
      func_q <= func_e'(in_user_i);
      idx_q  <= in_data_i[ID_W-1:0];
      pv_q   <= in_data_i[ID_W+VAL_W-1:ID_W];
    end
    if (cmd_i.scan_init) begin
      ptr_q <= '0;
    end else if (cmd_i.scan_rd) begin
      ptr_q <= ptr_q + AW'(1);
    end
    if (rd_ok_q && elig && better) begin
      best_idx_q <= rd_idx_q;
      best_age_q <= age;
      best_dl_q  <= dl_rd;
      best_pr_q  <= pr_rd;
    end
    if (cmd_i.emit_exp) begin
      out_ev_q   <= EV_EXP;
      out_id_q   <= bi_ext[ID_W-1:0];
      out_val_q  <= bdl_ext[VAL_W-1:0];
      out_last_q <= stat_o.exp_last;
    end else if (cmd_i.cmd_exec) begin
      out_ev_q   <= ev_c;
      out_id_q   <= idx_q;
      out_val_q  <= val_c;
      out_last_q <= 1'b1;
    end
  end

  assign stat_o.in_is_tick = (in_user_i == FN_TICK);
  assign stat_o.ptr_last   = (ptr_q == AW'(TIMERS - 1));
  assign stat_o.best_found = best_found_q;
  assign stat_o.exp_last   = (n_nxt == total_ext) || (n_nxt == CMPW'(MAX_RES));
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_ev_q;
  assign out_last_o  = out_last_q;
  assign out_data_o  = {{(OUT_TDATA_W-VAL_W-ID_W){1'b0}}, out_val_q, out_id_q};

endmodule

`default_nettype wire

>>> hdl/multi_timer_expiry_manager.sv
// Timer list with its own tick counter.
// Input stream (s_axis): one transaction is a command or a tick. tuser holds
// the function code, tdata the timer index and a period. Every command gives
// exactly one status result; a tick gives one expiry result per timer whose
// deadline has been reached, oldest deadline first, lower index on ties,
// at most MAX_RES of them, tlast on the final one. A tick with no expiry
// gives nothing.
// Output stream (m_axis): tuser is the event code, tdata the timer id and a
// value, tlast closes the results of one input transaction.
// Sequence: a command reads its stores after acceptance, then loads its
// result. A tick first advances the counter, then makes one pass over the
// timer list per expiry result (deadline and period stores are
// single-read-port RAMs read one entry a cycle); with no expiry the block is
// ready again after that single pass. One transaction is worked on at a
// time: tready is high only while the block is idle.
// A single output register decouples the sides: a new input is accepted
// while a result waits, and the block stalls only when a new result must be
// loaded while the previous one has not been taken.
// Reset: counter zero, all timers inactive and one-shot, periods and
// deadlines read as zero (per-entry valid bits, no clearing pass).
`default_nettype none

module multi_timer_expiry_manager #(
  parameter int TIMERS    = 16,
  parameter int TICK_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // [3:0] timer_index, [35:4] period_value, [39:36] zero
  input  wire logic [mtem_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [2:0] func
  input  wire logic [mtem_pkg::FUNC_W-1:0]         s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // [3:0] timer_id, [35:4] read_value, [39:36] zero
  output logic      [mtem_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // [1:0] event_res
  output logic      [mtem_pkg::EV_W-1:0]           m_axis_tuser,
  output logic                                     m_axis_tlast
);

  import mtem_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: accept, command read/execute, tick scan passes, emission
  mtem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // timer state, stores, scan compare and output register
  mtem_dp #(
    .TIMERS    (TIMERS),
    .TICK_BITS (TICK_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_user_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_user_o  (m_axis_tuser),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  // a result is only loaded into a free (or draining) output register
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_exp || cmd.cmd_exec) |-> stat.out_free)
    else $error("result loaded over a pending result");

  // accept, command execute and expiry emission never coincide
  a_excl_ops : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.cmd_exec, cmd.emit_exp}))
    else $error("conflicting datapath commands");

  // no input transaction is taken while the list is being scanned
  a_scan_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.scan_rd |-> !s_axis_tready)
    else $error("ready during scan");

  // a loaded expiry result always shows up at the output next cycle
  a_exp_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_exp |=> (m_axis_tvalid && m_axis_tuser == EV_EXP))
    else $error("expiry result not presented");

endmodule

`default_nettype wire

>>> verif/tb_multi_timer_expiry_manager.sv
module tb_multi_timer_expiry_manager;
  timeunit 1ns;
  timeprecision 1ps;

  import mtem_pkg::*;

  localparam int          TIMERS     = 16;
  // A deadline counts as reached while the wrapped distance stays below this
  localparam logic [31:0] TICK_HALF  = 32'h7FFF_FFFF;
  // Worst quiet time after the last result: a tick scan with no expiry
  localparam int          SCAN_TAIL  = TIMERS + 8;
  localparam int          DRAIN_MAX  = 200000;
  localparam int          HOLD_LEN   = 300;
  localparam int          PHASE_REQS = 70;

  // One output transaction as seen on m_axis
  typedef struct packed {
    ev_e              ev;
    logic [ID_W-1:0]  id;
    logic [VAL_W-1:0] val;
    logic             last;
  } timer_event_t;

  // One directed stimulus row; typed rows carry their single status result
  typedef struct packed {
    func_e            fn;
    logic [ID_W-1:0]  idx;
    logic [VAL_W-1:0] per;
    logic             typed;
    ev_e              ev;
    logic [VAL_W-1:0] val;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [3:0] timer_index, [35:4] period_value
  logic [FUNC_W-1:0]      s_axis_tuser;   // [2:0] func
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [3:0] timer_id, [35:4] read_value
  logic [EV_W-1:0]        m_axis_tuser;   // [1:0] event_res
  logic                   m_axis_tlast;

  multi_timer_expiry_manager #(
    .TIMERS   (TIMERS),
    .TICK_BITS(32)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // Shadow of the timer list
  logic [31:0] now_tick_q;
  logic [31:0] deadline_q [TIMERS];
  logic [31:0] period_q   [TIMERS];
  logic        active_q   [TIMERS];
  logic        periodic_q [TIMERS];

  timer_event_t step_events[$];     // results of the transaction just accepted
  timer_event_t pending_events[$];  // results still owed by the block

  // Side info for the transaction on s_axis (typed expectation of a directed row)
  logic        row_typed;
  ev_e         row_ev;
  logic [31:0] row_val;

  int send_pct   = 0;   // chance (percent) of a sender idle cycle
  int stall_pct  = 0;   // chance (percent) of a receiver stall cycle
  bit hold_req   = 1'b0;
  int mismatches = 0;
  int n_cmds     = 0;
  int n_ticks    = 0;
  int n_expiries = 0;
  int n_errors   = 0;

  // Works out the results of one input transaction and updates the shadow.
  function automatic void timer_list_step(func_e fn, logic [3:0] idx, logic [31:0] pv);
    logic [31:0]  age [TIMERS];
    bit           cand [TIMERS];
    int           best;
    logic [31:0]  fired;
    ev_e          ev;
    logic [31:0]  val;
    timer_event_t tail;
    step_events.delete();
    if (fn == FN_TICK) begin
      now_tick_q = now_tick_q + 32'd1;
      // every candidate is judged against the new count before any re-arm
      for (int i = 0; i < TIMERS; i++) begin
        age[i]  = now_tick_q - deadline_q[i];
        cand[i] = active_q[i] && (age[i] < TICK_HALF);
      end
      for (int k = 0; k < MAX_RES; k++) begin
        best = -1;
        // oldest deadline wins; strict compare keeps the lower index on ties
        for (int i = 0; i < TIMERS; i++) begin
          if (cand[i] && (best < 0 || age[i] > age[best])) best = i;
        end
        if (best >= 0) begin
          cand[best] = 1'b0;
          fired      = deadline_q[best];
          if (periodic_q[best] && period_q[best] < TICK_HALF) begin
            deadline_q[best] = now_tick_q + period_q[best];
          end else begin
            active_q[best] = 1'b0;
          end
          step_events.push_back(timer_event_t'{EV_EXP, 4'(best), fired, 1'b0});
        end
      end
      if (step_events.size() > 0) begin
        tail      = step_events.pop_back();
        tail.last = 1'b1;
        step_events.push_back(tail);
      end
    end else begin
      ev  = EV_DONE;
      val = '0;
      case (fn)
        FN_START: begin
          if (period_q[idx] >= TICK_HALF) begin
            ev = EV_ERR;
          end else begin
            deadline_q[idx] = now_tick_q + period_q[idx];
            active_q[idx]   = 1'b1;
          end
        end
        FN_STOP: begin
          if (!active_q[idx]) ev = EV_ERR;
          else active_q[idx] = 1'b0;
        end
        FN_SETP:     period_q[idx]   = pv;
        FN_GETP:     val             = period_q[idx];
        FN_ONESHOT:  periodic_q[idx] = 1'b0;
        FN_PERIODIC: periodic_q[idx] = 1'b1;
        default:     ev              = EV_ERR;
      endcase
      step_events.push_back(timer_event_t'{ev, idx, val, 1'b1});
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #10ms;
    $display("tb_multi_timer_expiry_manager NOT OK");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off counted here on request
  initial begin : rx_side
    int hold_left;
    hold_left     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HOLD_LEN;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Monitor: check output transactions first, then predict the accepted input.
  // A result never leaves in the cycle its input is taken, so this order is safe.
  always @(posedge clk_i) begin : monitor
    timer_event_t got;
    timer_event_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = timer_event_t'{ev_e'(m_axis_tuser), m_axis_tdata[3:0],
                           m_axis_tdata[35:4], m_axis_tlast};
      if (got.ev == EV_EXP) n_expiries++;
      if (got.ev == EV_ERR) n_errors++;
      if (pending_events.size() == 0) begin
        $display("%0t: expected no result, got ev=%0d id=%0d val=%h last=%0b",
                 $time, got.ev, got.id, got.val, got.last);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (got.ev !== want.ev || got.id !== want.id || got.val !== want.val ||
            got.last !== want.last) begin
          $display("%0t: mismatch expected ev=%0d id=%0d val=%h last=%0b,",
                   $time, want.ev, want.id, want.val, want.last);
          $display("%0t:          got ev=%0d id=%0d val=%h last=%0b",
                   $time, got.ev, got.id, got.val, got.last);
          mismatches++;
        end
      end
    end
    if (s_axis_tvalid && s_axis_tready) begin
      timer_list_step(func_e'(s_axis_tuser), s_axis_tdata[3:0], s_axis_tdata[35:4]);
      if (row_typed) begin
        pending_events.push_back(timer_event_t'{row_ev, s_axis_tdata[3:0], row_val, 1'b1});
      end else begin
        foreach (step_events[i]) pending_events.push_back(step_events[i]);
      end
      if (func_e'(s_axis_tuser) == FN_TICK) n_ticks++;
      else n_cmds++;
    end
  end

  // Offer one transaction (after random idle cycles) and wait until it is taken.
  // tvalid stays high when the next call follows without a gap.
  task automatic send_req(input func_e fn, input logic [3:0] idx, input logic [31:0] pv,
                          input logic typed = 1'b0, input ev_e ev = EV_DONE,
                          input logic [31:0] val = '0);
    @(negedge clk_i);
    while ($urandom_range(99) < send_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'b0, pv, idx};
    s_axis_tuser  = fn;
    row_typed     = typed;
    row_ev        = ev;
    row_val       = val;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Sender pause: nothing offered until every owed result has arrived,
  // then long enough for a silent tick scan to finish.
  task automatic drain_results();
    int guard;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    row_typed     = 1'b0;
    guard         = 0;
    while (pending_events.size() != 0 && guard < DRAIN_MAX) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SCAN_TAIL) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_period();
    int r;
    r = $urandom_range(99);
    if (r < 55)      pick_period = 32'($urandom_range(6));
    else if (r < 70) pick_period = $urandom;
    else if (r < 82) pick_period = 32'h7FFF_FFFE + 32'($urandom_range(2));
    else             pick_period = 32'($urandom_range(60, 7));
  endfunction

  task automatic send_random_req();
    int          r;
    func_e       fn;
    logic [3:0]  idx;
    r   = $urandom_range(99);
    idx = 4'($urandom_range(15));
    if (r < 30)      fn = FN_TICK;
    else if (r < 42) fn = FN_START;
    else if (r < 52) fn = FN_STOP;
    else if (r < 67) fn = FN_SETP;
    else if (r < 75) fn = FN_GETP;
    else if (r < 83) fn = FN_ONESHOT;
    else if (r < 94) fn = FN_PERIODIC;
    else             fn = FN_INVALID;
    // period and index bits are random on every command, also where ignored
    send_req(fn, idx, pick_period());
  endtask

  initial begin : stimulus
    stim_row_t  dir_tab [26];
    int         sent;
    int         n;
    logic [3:0] idx;
    bit         hold_done;

    // Directed rows: reset values, error cases and the start limit are typed in,
    // the rest goes through the predictor.
    dir_tab[0]  = stim_row_t'{FN_GETP,     4'd0,  32'd0,         1'b1, EV_DONE, 32'd0};
    dir_tab[1]  = stim_row_t'{FN_STOP,     4'd15, 32'd0,         1'b1, EV_ERR,  32'd0};
    dir_tab[2]  = stim_row_t'{FN_INVALID,  4'd5,  32'hFFFF_FFFF, 1'b1, EV_ERR,  32'd0};
    dir_tab[3]  = stim_row_t'{FN_TICK,     4'd9,  32'hFFFF_FFFF, 1'b0, EV_DONE, 32'd0};
    dir_tab[4]  = stim_row_t'{FN_SETP,     4'd15, 32'hFFFF_FFFF, 1'b1, EV_DONE, 32'd0};
    dir_tab[5]  = stim_row_t'{FN_GETP,     4'd15, 32'd0,         1'b1, EV_DONE, 32'hFFFF_FFFF};
    dir_tab[6]  = stim_row_t'{FN_START,    4'd15, 32'd0,         1'b1, EV_ERR,  32'd0};
    dir_tab[7]  = stim_row_t'{FN_SETP,     4'd14, 32'h7FFF_FFFF, 1'b1, EV_DONE, 32'd0};
    dir_tab[8]  = stim_row_t'{FN_START,    4'd14, 32'd0,         1'b1, EV_ERR,  32'd0};
    dir_tab[9]  = stim_row_t'{FN_SETP,     4'd14, 32'h7FFF_FFFE, 1'b1, EV_DONE, 32'd0};
    dir_tab[10] = stim_row_t'{FN_START,    4'd14, 32'd0,         1'b0, EV_DONE, 32'd0};
    dir_tab[11] = stim_row_t'{FN_PERIODIC, 4'd0,  32'd0,         1'b1, EV_DONE, 32'd0};
    dir_tab[12] = stim_row_t'{FN_START,    4'd0,  32'd0,         1'b0, EV_DONE, 32'd0};
    dir_tab[13] = stim_row_t'{FN_SETP,     4'd1,  32'd1,         1'b1, EV_DONE, 32'd0};
    dir_tab[14] = stim_row_t'{FN_START,    4'd1,  32'd0,         1'b0, EV_DONE, 32'd0};
    dir_tab[15] = stim_row_t'{FN_SETP,     4'd2,  32'd3,         1'b1, EV_DONE, 32'd0};
    dir_tab[16] = stim_row_t'{FN_PERIODIC, 4'd2,  32'd0,         1'b1, EV_DONE, 32'd0};
    dir_tab[17] = stim_row_t'{FN_START,    4'd2,  32'd0,         1'b0, EV_DONE, 32'd0};
    // zero-period timer (older deadline) ahead of the one-shot on the same tick
    dir_tab[18] = stim_row_t'{FN_TICK,     4'd0,  32'd0,         1'b0, EV_DONE, 32'd0};
    dir_tab[19] = stim_row_t'{FN_TICK,     4'd0,  32'd0,         1'b0, EV_DONE, 32'd0};
    // period raised past the limit while active: dropped instead of re-armed
    dir_tab[20] = stim_row_t'{FN_SETP,     4'd0,  32'h8000_0000, 1'b0, EV_DONE, 32'd0};
    dir_tab[21] = stim_row_t'{FN_TICK,     4'd0,  32'd0,         1'b0, EV_DONE, 32'd0};
    dir_tab[22] = stim_row_t'{FN_STOP,     4'd0,  32'd0,         1'b0, EV_DONE, 32'd0};
    dir_tab[23] = stim_row_t'{FN_ONESHOT,  4'd2,  32'd0,         1'b0, EV_DONE, 32'd0};
    dir_tab[24] = stim_row_t'{FN_TICK,     4'd0,  32'd0,         1'b0, EV_DONE, 32'd0};
    dir_tab[25] = stim_row_t'{FN_STOP,     4'd14, 32'd0,         1'b0, EV_DONE, 32'd0};

    // Shadow at its reset values
    now_tick_q = '0;
    for (int i = 0; i < TIMERS; i++) begin
      deadline_q[i] = '0;
      period_q[i]   = '0;
      active_q[i]   = 1'b0;
      periodic_q[i] = 1'b0;
    end
    hold_done = 1'b0;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FN_TICK;
    row_typed     = 1'b0;
    row_ev        = EV_DONE;
    row_val       = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i])
      send_req(dir_tab[i].fn, dir_tab[i].idx, dir_tab[i].per,
               dir_tab[i].typed, dir_tab[i].ev, dir_tab[i].val);
    drain_results();

    // Random part, one idle mode per phase
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 60; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 60; end
        default: begin send_pct = 34; stall_pct = 34; end
      endcase

      if (phase == 3) begin
        // every timer periodic with zero period: full 16-result ticks
        for (int i = 0; i < TIMERS; i++) begin
          send_req(FN_SETP, 4'(i), 32'd0);
          send_req(FN_PERIODIC, 4'(i), $urandom);
          send_req(FN_START, 4'(i), $urandom);
        end
        send_req(FN_TICK, 4'($urandom_range(15)), $urandom);
        send_req(FN_TICK, 4'($urandom_range(15)), $urandom);
        for (int i = 0; i < TIMERS; i++) send_req(FN_STOP, 4'(i), $urandom);
      end

      sent = 0;
      while (sent < PHASE_REQS) begin
        // output held off for a long stretch while the sender keeps offering
        if (phase == 0 && !hold_done && sent >= 20) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
        if ($urandom_range(99) < 35) begin
          // arm sequence with random content, followed by a few ticks
          idx = 4'($urandom_range(15));
          send_req(FN_SETP, idx, pick_period());
          send_req($urandom_range(1) ? FN_PERIODIC : FN_ONESHOT, idx, $urandom);
          send_req(FN_START, idx, $urandom);
          n = $urandom_range(3, 1);
          for (int k = 0; k < n; k++) send_req(FN_TICK, 4'($urandom_range(15)), $urandom);
          sent += 3 + n;
        end else begin
          send_random_req();
          sent++;
        end
      end
      drain_results();
    end

    stall_pct = 0;
    drain_results();
    if (pending_events.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_events.size());
      mismatches++;
    end

    $display("Run covered %0d commands and %0d ticks; %0d expiries and %0d error statuses",
             n_cmds, n_ticks, n_expiries, n_errors);
    $display("Idle modes: none, sender gaps, receiver stalls, both; one long output hold-off");
    if (mismatches == 0) begin
      $display("tb_multi_timer_expiry_manager OK");
    end else begin
      $display("tb_multi_timer_expiry_manager NOT OK");
    end
    $finish;
  end

endmodule
